[rtl/fmpc_pkg.sv]
// Shared types, codes and sizes for the first-match packet classifier.
// Used by every module of the block; depends on nothing else.

package fmpc_pkg;

    // Rule table size and the widths that follow from it.
    localparam int MAX_RULES = 16;
    localparam int IDX_W     = $clog2(MAX_RULES);
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    // Command queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Stream widths.
    localparam int S_DATA_W = 152;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

    // Operation codes.
    typedef logic [1:0] t_op;
    localparam t_op OP_CLASSIFY = 2'd0;
    localparam t_op OP_ADD      = 2'd1;
    localparam t_op OP_MODIFY   = 2'd2;
    localparam t_op OP_NONE     = 2'd3;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_BAD_PROTO = 2'd3;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Wildcard mask bit positions.
    localparam int WC_SRC_ADDR = 0;
    localparam int WC_DST_ADDR = 1;
    localparam int WC_PROTO    = 2;
    localparam int WC_SRC_PORT = 3;
    localparam int WC_DST_PORT = 4;

    // One decoded command as it travels from the front to the back part.
    typedef struct packed {
        t_op         op;
        logic        bad_proto;
        logic        has_ports;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  ip_protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [4:0]  wildcard_mask;
        logic [31:0] rule_id;
        logic [7:0]  target_queue;
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] new_rule_id;
        logic        matched;
        logic [7:0]  queue_id;
    } t_result;

endpackage

[rtl/fmpc_front.sv]
// Front part of the classifier: unpacks an input beat and decodes it into a command.
// Depends on fmpc_pkg.

module fmpc_front (
    input  logic                          i_valid,
    input  logic [fmpc_pkg::S_DATA_W-1:0] i_data,
    input  logic [fmpc_pkg::S_USER_W-1:0] i_user,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output fmpc_pkg::t_cmd                o_cmd
);

    logic [7:0] proto;
    logic       is_icmp;
    logic       known;

    // A beat is taken whenever the command queue has room.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Protocol check: only ICMP, TCP and UDP can be classified; ICMP carries no ports.
    assign proto   = i_data[71:64];
    assign is_icmp = (proto == fmpc_pkg::PROTO_ICMP);
    assign known   = is_icmp || (proto == fmpc_pkg::PROTO_TCP)
                     || (proto == fmpc_pkg::PROTO_UDP);

    // Unpack the fields of the beat.
    always_comb begin
        o_cmd.op            = i_user;
        o_cmd.bad_proto     = !known;
        o_cmd.has_ports     = !is_icmp;
        o_cmd.src_ip        = i_data[31:0];
        o_cmd.dst_ip        = i_data[63:32];
        o_cmd.ip_protocol   = proto;
        o_cmd.sport         = i_data[87:72];
        o_cmd.dport         = i_data[103:88];
        o_cmd.wildcard_mask = i_data[108:104];
        o_cmd.rule_id       = i_data[140:109];
        o_cmd.target_queue  = i_data[148:141];
    end

endmodule

[rtl/fmpc_fifo.sv]
// Short command queue that decouples the front part from the back part.
// Depends on fmpc_pkg.

module fmpc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fmpc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fmpc_pkg::t_cmd o_cmd
);

    fmpc_pkg::t_cmd                r_mem [fmpc_pkg::FIFO_DEPTH];
    logic [fmpc_pkg::FIFO_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [fmpc_pkg::FIFO_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [fmpc_pkg::FIFO_CW-1:0]  r_fill, n_fill;

    assign o_full  = (r_fill == fmpc_pkg::FIFO_CW'(fmpc_pkg::FIFO_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill level updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Storage is written at the write pointer only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/fmpc_back.sv]
// Back part of the classifier: holds the rule table, executes commands and
// registers each result for the output stream. Depends on fmpc_pkg.

module fmpc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fmpc_pkg::t_cmd        i_cmd,
    output logic                  o_pop,
    input  logic [7:0]            i_default_queue,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmpc_pkg::t_result     o_result
);

    // Rule table, one lane per rule; entries at or above the count are never read.
    logic [31:0] r_sa    [fmpc_pkg::MAX_RULES];
    logic [31:0] r_da    [fmpc_pkg::MAX_RULES];
    logic [7:0]  r_proto [fmpc_pkg::MAX_RULES];
    logic [15:0] r_sp    [fmpc_pkg::MAX_RULES];
    logic [15:0] r_dp    [fmpc_pkg::MAX_RULES];
    logic [4:0]  r_mask  [fmpc_pkg::MAX_RULES];
    logic [31:0] r_id    [fmpc_pkg::MAX_RULES];
    logic [7:0]  r_queue [fmpc_pkg::MAX_RULES];

    logic [fmpc_pkg::CNT_W-1:0] r_count;
    logic [31:0]                r_next_id;

    logic                       r_out_valid;
    fmpc_pkg::t_result          r_out;
    fmpc_pkg::t_result          n_out;

    logic [fmpc_pkg::MAX_RULES-1:0] lane_match;
    logic [fmpc_pkg::MAX_RULES-1:0] lane_id_hit;
    logic                           match_any;
    logic [fmpc_pkg::IDX_W-1:0]     match_idx;
    logic                           id_any;
    logic [fmpc_pkg::IDX_W-1:0]     id_idx;
    logic                           table_full;
    logic                           exec;
    logic                           do_add;
    logic                           do_modify;
    logic [fmpc_pkg::IDX_W-1:0]     wr_slot;

    // A command is carried out when the output register is free or being emptied.
    assign exec    = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = exec;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    assign table_full = (r_count == fmpc_pkg::CNT_W'(fmpc_pkg::MAX_RULES));

    // Every lane compares its rule with the packet and with the rule id at once.
    always_comb begin
        for (int i = 0; i < fmpc_pkg::MAX_RULES; i++) begin
            lane_match[i] = (fmpc_pkg::CNT_W'(i) < r_count)
                && (r_mask[i][fmpc_pkg::WC_SRC_ADDR] || (r_sa[i] == i_cmd.src_ip))
                && (r_mask[i][fmpc_pkg::WC_DST_ADDR] || (r_da[i] == i_cmd.dst_ip))
                && (r_mask[i][fmpc_pkg::WC_PROTO] || (r_proto[i] == i_cmd.ip_protocol))
                && (r_mask[i][fmpc_pkg::WC_SRC_PORT]
                    || (i_cmd.has_ports && (r_sp[i] == i_cmd.sport)))
                && (r_mask[i][fmpc_pkg::WC_DST_PORT]
                    || (i_cmd.has_ports && (r_dp[i] == i_cmd.dport)));
            lane_id_hit[i] = (fmpc_pkg::CNT_W'(i) < r_count) && (r_id[i] == i_cmd.rule_id);
        end
    end

    // Priority pick: the lowest lane that hits wins.
    always_comb begin
        match_any = |lane_match;
        id_any    = |lane_id_hit;
        match_idx = '0;
        id_idx    = '0;
        for (int i = fmpc_pkg::MAX_RULES - 1; i >= 0; i--) begin
            if (lane_match[i]) begin
                match_idx = fmpc_pkg::IDX_W'(i);
            end
            if (lane_id_hit[i]) begin
                id_idx = fmpc_pkg::IDX_W'(i);
            end
        end
    end

    // Result of the command and the table write it causes.
    always_comb begin
        n_out     = '0;
        do_add    = 1'b0;
        do_modify = 1'b0;
        unique case (i_cmd.op)
            fmpc_pkg::OP_CLASSIFY: begin
                n_out.queue_id = i_default_queue;
                if (i_cmd.bad_proto) begin
                    n_out.status = fmpc_pkg::ST_BAD_PROTO;
                end else if (match_any) begin
                    n_out.queue_id = r_queue[match_idx];
                    n_out.matched  = 1'b1;
                end
            end
            fmpc_pkg::OP_ADD: begin
                if (table_full) begin
                    n_out.status = fmpc_pkg::ST_FULL;
                end else begin
                    n_out.new_rule_id = r_next_id;
                    do_add            = 1'b1;
                end
            end
            fmpc_pkg::OP_MODIFY: begin
                if (id_any) begin
                    do_modify = 1'b1;
                end else begin
                    n_out.status = fmpc_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
        wr_slot = do_add ? r_count[fmpc_pkg::IDX_W-1:0] : id_idx;
    end

    // Control state: rule count, id counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec && do_add) begin
                r_count   <= r_count + 1'b1;
                r_next_id <= r_next_id + 32'd1;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

    // Rule table writes; an add also sets the rule id.
    always_ff @(posedge i_clk) begin
        if (exec && (do_add || do_modify)) begin
            r_sa[wr_slot]    <= i_cmd.src_ip;
            r_da[wr_slot]    <= i_cmd.dst_ip;
            r_proto[wr_slot] <= i_cmd.ip_protocol;
            r_sp[wr_slot]    <= i_cmd.sport;
            r_dp[wr_slot]    <= i_cmd.dport;
            r_mask[wr_slot]  <= i_cmd.wildcard_mask;
            r_queue[wr_slot] <= i_cmd.target_queue;
        end
        if (exec && do_add) begin
            r_id[wr_slot] <= r_next_id;
        end
    end

endmodule

[rtl/first_match_packet_classifier.sv]
// Top level of the first-match packet classifier.
// Instantiates fmpc_front, fmpc_fifo and fmpc_back; depends on fmpc_pkg.
//
// Usage:
//   Input beats arrive on s_axis_*: tuser carries the operation (classify, add
//   rule, modify rule), tdata the header or rule fields. Every beat gives exactly
//   one result beat on m_axis_*, in order.
//   The default queue is written on the i_cfg_* channel, which is always ready;
//   write it only while no beat is in flight.
//   Each accepted beat is registered in the command queue and then, when the
//   back part executes it, in the output register that drives m_axis_*.
//   Throughput: one beat per cycle while the receiver is ready; the back part
//   compares all 16 rules in parallel lanes. A four-entry command queue sits
//   between the decoding front part and the back part. When the receiver
//   stalls, the result is held in the output register, commands gather in the
//   queue, and s_axis_tready falls once the queue is full.
//   Reset (i_rst_n low at a clock edge) empties the table and the queue, sets
//   the next rule id and the default queue to zero, and drops m_axis_tvalid.
//   The table holds up to 16 rules; further adds are reported as table full.

module first_match_packet_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, from bit 0: src_ip[31:0], dst_ip[63:32], ip_protocol[71:64],
    // sport[87:72], dport[103:88], wildcard_mask[108:104], rule_id[140:109],
    // target_queue[148:141], zero fill[151:149].
    input  logic [151:0] s_axis_tdata,
    // tuser: operation[1:0].
    input  logic [1:0]   s_axis_tuser,
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, from bit 0: queue_id[7:0], matched[8], new_rule_id[40:9],
    // status[42:41], zero fill[47:43].
    output logic [47:0]  m_axis_tdata,
    // Configuration write channel: default queue.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);

    logic              front_push;
    logic              fifo_full;
    logic              fifo_valid;
    logic              back_pop;
    fmpc_pkg::t_cmd    front_cmd;
    fmpc_pkg::t_cmd    fifo_cmd;
    fmpc_pkg::t_result back_result;
    logic [7:0]        r_default_queue;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_queue <= '0;
        end else if (i_cfg_valid) begin
            r_default_queue <= i_cfg_data;
        end
    end

    // Decode of input beats.
    fmpc_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_full  (fifo_full),
        .o_ready (s_axis_tready),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    // Command queue.
    fmpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (back_pop),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd)
    );

    // Rule table and execution.
    fmpc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (fifo_valid),
        .i_cmd           (fifo_cmd),
        .o_pop           (back_pop),
        .i_default_queue (r_default_queue),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_result        (back_result)
    );

    // Pack the result beat.
    assign m_axis_tdata = {5'd0, back_result.status, back_result.new_rule_id,
                           back_result.matched, back_result.queue_id};

endmodule
